// File: rtl/core/cbmm_pkg.sv
// Shared constants, types and the codebook lookup for the codebook int8 matmul tile.
// No dependencies; every module of the block imports this package.
package cbmm_pkg;

    localparam int TILE_ROWS = 4;
    localparam int TILE_COLS = 4;
    localparam int NUM_ELEM  = TILE_ROWS * TILE_COLS;

    // Rows and columns carried on the input stream.
    localparam int IN_ROWS = 4;
    localparam int IN_COLS = 4;

    localparam int ACT_PAIR_W = 16;
    localparam int WBYTE_W    = 8;
    localparam int NIBBLE_W   = 4;
    localparam int ACC_W      = 32;
    localparam int CB_W       = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CODEBOOK_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CODEBOOK_HIGH = 1'b1;

    localparam int IN_DATA_W  = IN_ROWS * ACT_PAIR_W + IN_COLS * WBYTE_W;
    localparam int OUT_ITEM_W = 2 + 2 + ACC_W;
    localparam int OUT_DATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

    localparam int ELEM_CNT_W = (NUM_ELEM > 1) ? $clog2(NUM_ELEM) : 1;
    localparam int ROW_CNT_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int COL_CNT_W  = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

    typedef logic [NUM_ELEM-1:0][ACC_W-1:0] acc_array_t;

    typedef struct packed {
        logic [1:0]       out_row;
        logic [1:0]       out_col;
        logic [ACC_W-1:0] sum_value;
        logic             last_of_tile;
    } out_item_t;

    // Codebook entry idx of the 16-entry table, entry 0 in the lowest byte.
    function automatic logic signed [7:0] cb_entry(
        input logic [2*CB_W-1:0]   cb,
        input logic [NIBBLE_W-1:0] idx
    );
        cb_entry = cb[{idx, 3'b000} +: 8];
    endfunction

endpackage

// File: rtl/core/cbmm_lane.sv
// One multiply-accumulate lane: two codebook lookups, two int8 products and a wrapping
// int32 accumulator for a single tile element. Depends on cbmm_pkg.
module cbmm_lane
    import cbmm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    clear,
    input  logic [ACT_PAIR_W-1:0]   act_pair,
    input  logic [WBYTE_W-1:0]      wbyte,
    input  logic [2*CB_W-1:0]       codebook,
    output logic [ACC_W-1:0]        total
);

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic signed [7:0]  a_even;
    logic signed [7:0]  a_odd;
    logic signed [7:0]  w_even;
    logic signed [7:0]  w_odd;
    logic signed [15:0] p_even;
    logic signed [15:0] p_odd;
    logic signed [16:0] p_sum;

    assign a_even = act_pair[7:0];
    assign a_odd  = act_pair[15:8];
    assign w_even = cb_entry(codebook, wbyte[NIBBLE_W-1:0]);
    assign w_odd  = cb_entry(codebook, wbyte[WBYTE_W-1:NIBBLE_W]);

    assign p_even = a_even * w_even;
    assign p_odd  = a_odd * w_odd;
    assign p_sum  = 17'(p_even) + 17'(p_odd);

    assign total = acc_reg + ACC_W'(p_sum);

    always_comb
    begin
        acc_next = acc_reg;
        if (en)
        begin
            acc_next = clear ? '0 : total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// File: rtl/core/cbmm_drain.sv
// Merging stage: captures all lane sums of a finished tile and sends them out row-major.
// Depends on cbmm_pkg.
module cbmm_drain
    import cbmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  acc_array_t  sums,
    input  logic        item_ready,
    output logic        item_valid,
    output logic        free,
    output out_item_t   item
);

    logic [ACC_W-1:0]      buf_reg  [NUM_ELEM];
    logic [ACC_W-1:0]      buf_next [NUM_ELEM];
    logic                  busy_reg;
    logic                  busy_next;
    logic [ELEM_CNT_W-1:0] cnt_reg;
    logic [ELEM_CNT_W-1:0] cnt_next;
    logic [ROW_CNT_W-1:0]  row_reg;
    logic [ROW_CNT_W-1:0]  row_next;
    logic [COL_CNT_W-1:0]  col_reg;
    logic [COL_CNT_W-1:0]  col_next;
    logic                  take;
    logic                  at_end;

    assign take   = busy_reg && item_ready;
    assign at_end = (cnt_reg == ELEM_CNT_W'(NUM_ELEM - 1));
    assign free   = !busy_reg || (take && at_end);

    assign item_valid        = busy_reg;
    assign item.out_row      = 2'(row_reg);
    assign item.out_col      = 2'(col_reg);
    assign item.sum_value    = buf_reg[0];
    assign item.last_of_tile = at_end;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            row_next  = '0;
            col_next  = '0;
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                buf_next[i] = sums[i];
            end
        end
        else if (take)
        begin
            busy_next = !at_end;
            cnt_next  = cnt_reg + 1'b1;
            if (col_reg == COL_CNT_W'(TILE_COLS - 1))
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
            // The buffer shifts so that the next sum always sits at the head.
            for (int i = 0; i < NUM_ELEM - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_ELEM; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("tile captured while the previous tile is still being sent");

    a_last_at_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && at_end) |->
        (row_reg == ROW_CNT_W'(TILE_ROWS - 1)) && (col_reg == COL_CNT_W'(TILE_COLS - 1)))
        else $error("last sum of the tile not at the final row and column");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !item_ready && !load) |=> $stable(cnt_reg) && busy_reg)
        else $error("drain position moved while the output was stalled");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (take && at_end && !load) |=> !busy_reg)
        else $error("drain still busy after the last sum was taken");

endmodule

// File: rtl/core/codebook_int8_matmul_tile_unit.sv
// Top level of the codebook int8 matmul tile: codebook registers, one MAC lane per tile
// element and the drain stage. Depends on cbmm_pkg, cbmm_lane and cbmm_drain.
//
//  Channel  Dir  Payload                                             Handshake
//  s_*      in   tdata: act rows 0..3 (16b each), wbytes 0..3 (8b);  tvalid/tready
//                tlast: last_of_depth
//  m_*      out  tdata: row, col, sum (zero pad to 40b);             tvalid/tready
//                tlast: last_of_tile
//  cfg_*    in   index 0 codebook_low, 1 codebook_high (64b)         cfg_we, no wait
//
// Each request is accumulated in the cycle it is accepted: one request per cycle while
// s_tready is high. A tlast request copies all sums into the drain buffer, which then
// sends TILE_ROWS*TILE_COLS results at one per cycle while m_tready is high, and new
// requests keep accumulating. A tlast request waits only while the previous tile is
// still in the drain buffer. Reset clears accumulators, codebook and drain control.
module codebook_int8_matmul_tile_unit
    import cbmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // act_pair_row0 [15:0], act_pair_row1 [31:16], act_pair_row2 [47:32],
    // act_pair_row3 [63:48], wbyte_col0 [71:64], wbyte_col1 [79:72],
    // wbyte_col2 [87:80], wbyte_col3 [95:88]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_row [1:0], out_col [3:2], sum_value [35:4], zero [39:36]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CB_W-1:0]       cfg_data
);

    logic [CB_W-1:0] cb_low_reg;
    logic [CB_W-1:0] cb_high_reg;
    logic            s_accept;
    logic            drain_free;
    logic            load;
    acc_array_t      totals;
    out_item_t       item;

    assign s_tready = !s_tlast || drain_free;
    assign s_accept = s_tvalid && s_tready;
    assign load     = s_accept && s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_low_reg  <= '0;
            cb_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CODEBOOK_LOW:  cb_low_reg  <= cfg_data;
                REG_CODEBOOK_HIGH: cb_high_reg <= cfg_data;
                default:           cb_low_reg  <= cb_low_reg;
            endcase
        end
    end

    for (genvar r = 0; r < TILE_ROWS; r++)
    begin : g_row
        logic [ACT_PAIR_W-1:0] act;
        if (r < IN_ROWS)
        begin : g_act
            assign act = s_tdata[r*ACT_PAIR_W +: ACT_PAIR_W];
        end
        else
        begin : g_act_zero
            assign act = '0;
        end

        for (genvar c = 0; c < TILE_COLS; c++)
        begin : g_col
            logic [WBYTE_W-1:0] wb;
            if (c < IN_COLS)
            begin : g_wb
                assign wb = s_tdata[IN_ROWS*ACT_PAIR_W + c*WBYTE_W +: WBYTE_W];
            end
            else
            begin : g_wb_zero
                assign wb = '0;
            end

            cbmm_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (s_accept),
                .clear    (s_tlast),
                .act_pair (act),
                .wbyte    (wb),
                .codebook ({cb_high_reg, cb_low_reg}),
                .total    (totals[r*TILE_COLS + c])
            );
        end
    end

    cbmm_drain u_drain (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .sums       (totals),
        .item_ready (m_tready),
        .item_valid (m_tvalid),
        .free       (drain_free),
        .item       (item)
    );

    assign m_tdata = OUT_DATA_W'({item.sum_value, item.out_col, item.out_row});
    assign m_tlast = item.last_of_tile;

endmodule
